/* sv/baruc_pkg.sv */
`default_nettype none

package baruc_pkg;

    localparam int unsigned VALUE_W = 8;
    localparam int unsigned BTN_W   = 2;

    localparam logic [VALUE_W-1:0] TOP_VALUE_RST   = 8'h09;
    localparam logic [VALUE_W-1:0] SHORT_HOLD_RST  = 8'h05;
    localparam logic [VALUE_W-1:0] LONG_HOLD_RST   = 8'd10;
    localparam logic [VALUE_W-1:0] REPEAT_TICK_RST = 8'h05;

    typedef enum logic [1:0] {
        CFG_TOP_VALUE   = 2'd0,
        CFG_SHORT_HOLD  = 2'd1,
        CFG_LONG_HOLD   = 2'd2,
        CFG_REPEAT_TICK = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [VALUE_W-1:0] top_value;
        logic [VALUE_W-1:0] short_hold;
        logic [VALUE_W-1:0] long_hold;
        logic [VALUE_W-1:0] repeat_tick;
    } cfg_t;

    typedef enum logic [8:0] {
        MODE_START   = 9'b000000001,
        MODE_IDLE    = 9'b000000010,
        MODE_PUSH_UP = 9'b000000100,
        MODE_PUSH_DN = 9'b000001000,
        MODE_CLEAR   = 9'b000010000,
        MODE_REP_UP  = 9'b000100000,
        MODE_REP_DN  = 9'b001000000,
        MODE_FAST_UP = 9'b010000000,
        MODE_FAST_DN = 9'b100000000
    } mode_t;

endpackage

`default_nettype wire

/* sv/baruc_fsm.sv */
`default_nettype none

module baruc_fsm
    import baruc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic [BTN_W-1:0]   buttons,
    input  wire cfg_t               cfg,
    output logic      [VALUE_W-1:0] value_next
);

    mode_t              mode_reg,  mode_next;
    logic [VALUE_W-1:0] hold_reg,  hold_next;
    logic [VALUE_W-1:0] count_reg, count_next;

    always_comb begin
        logic               up;
        logic               dn;
        logic               both;
        logic               do_up;
        logic               do_dn;
        mode_t              mid_mode;
        logic [VALUE_W-1:0] mid_hold;
        logic [VALUE_W-1:0] hold_inc;

        up       = buttons[0];
        dn       = buttons[1];
        both     = up & dn;
        do_up    = 1'b0;
        do_dn    = 1'b0;
        mid_mode = mode_reg;
        mid_hold = hold_reg;

        unique case (mode_reg)
            MODE_START, MODE_CLEAR: begin
                mid_mode = MODE_IDLE;
            end
            MODE_PUSH_UP, MODE_PUSH_DN: begin
                if (both) begin
                    mid_mode = MODE_CLEAR;
                end else if (hold_reg < cfg.short_hold) begin
                    if (mode_reg == MODE_PUSH_UP && !up) begin
                        do_up    = 1'b1;
                        mid_mode = MODE_IDLE;
                    end else if (mode_reg == MODE_PUSH_DN && !dn) begin
                        do_dn    = 1'b1;
                        mid_mode = MODE_IDLE;
                    end
                end else begin
                    mid_mode = (mode_reg == MODE_PUSH_UP) ? MODE_REP_UP : MODE_REP_DN;
                    mid_hold = '0;
                end
            end
            MODE_REP_UP, MODE_REP_DN: begin
                if (both) begin
                    mid_mode = MODE_CLEAR;
                end else if (hold_reg < cfg.long_hold) begin
                    if ((mode_reg == MODE_REP_UP) ? !up : !dn) begin
                        mid_mode = MODE_IDLE;
                    end
                end else begin
                    mid_mode = (mode_reg == MODE_REP_UP) ? MODE_FAST_UP : MODE_FAST_DN;
                    mid_hold = '0;
                end
            end
            MODE_FAST_UP, MODE_FAST_DN: begin
                if (both) begin
                    mid_mode = MODE_CLEAR;
                end else if ((mode_reg == MODE_FAST_UP) ? !up : !dn) begin
                    mid_mode = MODE_IDLE;
                end
            end
            default: begin
                mid_hold = '0;
                if (both) begin
                    mid_mode = MODE_CLEAR;
                end else if (up) begin
                    mid_mode = MODE_PUSH_UP;
                end else if (dn) begin
                    mid_mode = MODE_PUSH_DN;
                end else begin
                    mid_mode = MODE_IDLE;
                    mid_hold = hold_reg;
                end
            end
        endcase

        hold_inc   = mid_hold + 1'b1;
        mode_next  = mid_mode;
        hold_next  = hold_inc;
        count_next = count_reg;

        unique case (mid_mode)
            MODE_CLEAR: begin
                count_next = '0;
            end
            MODE_REP_UP: begin
                do_up = (hold_inc == cfg.repeat_tick);
            end
            MODE_REP_DN: begin
                do_dn = (hold_inc == cfg.repeat_tick);
            end
            MODE_FAST_UP: begin
                do_up = hold_inc[0];
            end
            MODE_FAST_DN: begin
                do_dn = hold_inc[0];
            end
            MODE_PUSH_UP, MODE_PUSH_DN: begin
            end
            default: begin
                hold_next = '0;
            end
        endcase

        if (do_up && count_reg < cfg.top_value) begin
            count_next = count_reg + 1'b1;
        end else if (do_dn && count_reg != '0) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_START;
            hold_reg  <= '0;
            count_reg <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
        end
    end

    assign value_next = count_next;

endmodule

`default_nettype wire

/* sv/button_auto_repeat_up_down_counter.sv */
// Up/down counter driven by two buttons, with auto-repeat and saturation.
// Input stream s_*: one word per tick, s_tdata[1:0] = buttons (bit0 up,
// bit1 down, active high). Result stream m_*: one word per input word,
// m_tdata = displayed value after that tick.
// Configuration channel cfg_*: cfg_index selects top_value, short_hold,
// long_hold or repeat_tick; cfg_data is the 8-bit value. Always ready.
// The result is registered into the output buffer. Throughput is one word
// per cycle: the state update is a single registered pass and the result
// side has a two-entry output buffer (output register plus skid register).
// When the receiver stalls, one more word is taken into the skid register,
// then s_tready drops until the receiver takes the waiting output word.
// Reset (aresetn low, synchronous) restores the register defaults
// (9, 5, 10, 5), clears the value and hold count, empties the output
// buffer and puts the controller into its start state.
`default_nettype none

module button_auto_repeat_up_down_counter
    import baruc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [1:0] buttons
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [7:0]   m_tdata,   // [7:0] value
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire cfg_idx_t     cfg_index,
    input  wire logic [7:0]   cfg_data
);

    cfg_t               cfg_reg;
    logic               push;
    logic               pop;
    logic [VALUE_W-1:0] value_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic               skid_valid_reg;
    logic [VALUE_W-1:0] skid_data_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign push      = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top_value   <= TOP_VALUE_RST;
            cfg_reg.short_hold  <= SHORT_HOLD_RST;
            cfg_reg.long_hold   <= LONG_HOLD_RST;
            cfg_reg.repeat_tick <= REPEAT_TICK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TOP_VALUE:   cfg_reg.top_value   <= cfg_data;
                CFG_SHORT_HOLD:  cfg_reg.short_hold  <= cfg_data;
                CFG_LONG_HOLD:   cfg_reg.long_hold   <= cfg_data;
                CFG_REPEAT_TICK: cfg_reg.repeat_tick <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    baruc_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (push),
        .buttons    (s_tdata[BTN_W-1:0]),
        .cfg        (cfg_reg),
        .value_next (value_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (out_valid_reg) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end else begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (push && (pop || !out_valid_reg)) begin
            out_data_reg <= value_next;
        end
        if (push && out_valid_reg && !pop) begin
            skid_data_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import baruc_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned MAX_SHOWN   = 10;

    localparam logic [1:0] BTN_NONE = 2'b00;
    localparam logic [1:0] BTN_UP   = 2'b01;
    localparam logic [1:0] BTN_DN   = 2'b10;
    localparam logic [1:0] BTN_BOTH = 2'b11;

    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    typedef struct packed {
        logic [1:0] buttons;
        logic       pinned;
        logic [7:0] value;
    } press_row_t;

    // default registers: top 9, short hold 5, long hold 10, repeat tick 5
    localparam press_row_t PRESS_TABLE [18] = '{
        '{BTN_NONE, 1'b1, 8'd0},
        '{BTN_DN,   1'b1, 8'd0},
        '{BTN_NONE, 1'b1, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_NONE, 1'b1, 8'd1},
        '{BTN_BOTH, 1'b1, 8'd0},
        '{BTN_BOTH, 1'b1, 8'd0},
        '{BTN_DN,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_NONE, 1'b0, 8'd0},
        '{BTN_NONE, 1'b0, 8'd0},
        '{BTN_UP,   1'b0, 8'd0},
        '{BTN_BOTH, 1'b1, 8'd0}
    };

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [1:0] buttons
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] value
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_idx_t   cfg_index;
    logic [7:0] cfg_data;

    button_auto_repeat_up_down_counter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    cfg_t       counter_regs = '{TOP_VALUE_RST, SHORT_HOLD_RST, LONG_HOLD_RST, REPEAT_TICK_RST};
    mode_t      press_mode   = MODE_START;
    logic [7:0] hold_count   = '0;
    logic [7:0] shown_value  = '0;

    logic [7:0] expected_values [$];
    logic       pinned_valid = 1'b0;
    logic [7:0] pinned_value = '0;
    logic [7:0] predicted_value;
    logic [7:0] wanted_value;

    int unsigned words_in       = 0;
    int unsigned values_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    function automatic void step_shown(input logic go_up);
        if (go_up) begin
            if (shown_value < counter_regs.top_value) shown_value = shown_value + 8'd1;
        end else begin
            if (shown_value > 8'd0) shown_value = shown_value - 8'd1;
        end
    endfunction

    function automatic logic [7:0] tick_counter(input logic [1:0] buttons);
        logic up;
        logic dn;
        logic both;
        logic mine;
        up   = buttons[0];
        dn   = buttons[1];
        both = (buttons == BTN_BOTH);
        case (press_mode)
            MODE_START, MODE_CLEAR: begin
                press_mode = MODE_IDLE;
            end
            MODE_PUSH_UP, MODE_PUSH_DN: begin
                mine = (press_mode == MODE_PUSH_UP) ? up : dn;
                if (both) begin
                    press_mode = MODE_CLEAR;
                end else if (hold_count < counter_regs.short_hold) begin
                    if (!mine) begin
                        step_shown(press_mode == MODE_PUSH_UP);
                        press_mode = MODE_IDLE;
                    end
                end else begin
                    press_mode = (press_mode == MODE_PUSH_UP) ? MODE_REP_UP : MODE_REP_DN;
                    hold_count = '0;
                end
            end
            MODE_REP_UP, MODE_REP_DN: begin
                mine = (press_mode == MODE_REP_UP) ? up : dn;
                if (both) begin
                    press_mode = MODE_CLEAR;
                end else if (hold_count < counter_regs.long_hold) begin
                    if (!mine) press_mode = MODE_IDLE;
                end else begin
                    press_mode = (press_mode == MODE_REP_UP) ? MODE_FAST_UP : MODE_FAST_DN;
                    hold_count = '0;
                end
            end
            MODE_FAST_UP, MODE_FAST_DN: begin
                mine = (press_mode == MODE_FAST_UP) ? up : dn;
                if (both) press_mode = MODE_CLEAR;
                else if (!mine) press_mode = MODE_IDLE;
            end
            default: begin
                if (both) begin
                    press_mode = MODE_CLEAR;
                    hold_count = '0;
                end else if (up) begin
                    press_mode = MODE_PUSH_UP;
                    hold_count = '0;
                end else if (dn) begin
                    press_mode = MODE_PUSH_DN;
                    hold_count = '0;
                end else begin
                    press_mode = MODE_IDLE;
                end
            end
        endcase

        case (press_mode)
            MODE_START, MODE_IDLE: begin
                hold_count = '0;
            end
            MODE_CLEAR: begin
                shown_value = '0;
                hold_count  = hold_count + 8'd1;
            end
            MODE_REP_UP, MODE_REP_DN: begin
                hold_count = hold_count + 8'd1;
                if (hold_count == counter_regs.repeat_tick) step_shown(press_mode == MODE_REP_UP);
            end
            MODE_FAST_UP, MODE_FAST_DN: begin
                hold_count = hold_count + 8'd1;
                if (hold_count[0]) step_shown(press_mode == MODE_FAST_UP);
            end
            default: begin
                hold_count = hold_count + 8'd1;
            end
        endcase
        return shown_value;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TOP_VALUE:   counter_regs.top_value   = cfg_data;
                    CFG_SHORT_HOLD:  counter_regs.short_hold  = cfg_data;
                    CFG_LONG_HOLD:   counter_regs.long_hold   = cfg_data;
                    CFG_REPEAT_TICK: counter_regs.repeat_tick = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predicted_value = tick_counter(s_tdata[1:0]);
                expected_values.push_back(pinned_valid ? pinned_value : predicted_value);
                words_in++;
            end
            if (m_tvalid && m_tready) begin
                values_checked++;
                if (expected_values.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected value word %0d: got %0d", values_checked, m_tdata);
                end else begin
                    wanted_value = expected_values.pop_front();
                    if (m_tdata !== wanted_value) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("value word %0d: expected %0d, got %0d",
                                     values_checked, wanted_value, m_tdata);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
                $display("** button_auto_repeat_up_down_counter: FAILED **");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_buttons(input logic [1:0] buttons, input logic pin, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid     = 1'b1;
        s_tdata      = {6'b0, buttons};
        pinned_valid = pin;
        pinned_value = value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_values.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic send_random(input int unsigned n_words);
        int unsigned sent;
        int unsigned pick;
        int unsigned hold_len;
        int unsigned sh;
        int unsigned lh;
        logic [1:0]  dir;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            sh   = counter_regs.short_hold;
            lh   = counter_regs.long_hold;
            if (pick < 75) begin
                dir = $urandom_range(1) ? BTN_UP : BTN_DN;
                case ($urandom_range(4))
                    0: hold_len = $urandom_range(sh, 1);
                    1: hold_len = sh + $urandom_range(2);
                    2: hold_len = sh + 1 + $urandom_range(lh);
                    3: hold_len = sh + lh + $urandom_range(3);
                    default: hold_len = sh + lh + 2 + $urandom_range(12);
                endcase
                if (hold_len == 0) hold_len = 1;
                if (hold_len > 600) hold_len = 600;
                repeat (hold_len) begin
                    send_buttons(dir, 1'b0, 8'd0);
                    sent++;
                end
                if ($urandom_range(9) == 0) begin
                    send_buttons(BTN_BOTH, 1'b0, 8'd0);
                    sent++;
                end
                repeat ($urandom_range(3, 1)) begin
                    send_buttons(BTN_NONE, 1'b0, 8'd0);
                    sent++;
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(2, 1)) begin
                    send_buttons(BTN_BOTH, 1'b0, 8'd0);
                    sent++;
                end
                send_buttons(BTN_NONE, 1'b0, 8'd0);
                sent++;
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_buttons(2'($urandom_range(3)), 1'b0, 8'd0);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_setting(input logic [7:0] top, input logic [7:0] sh, input logic [7:0] lh,
                               input logic [7:0] rt, input int idle_kind, input int unsigned n);
        drain_results();
        write_reg(CFG_TOP_VALUE, top);
        write_reg(CFG_SHORT_HOLD, sh);
        write_reg(CFG_LONG_HOLD, lh);
        write_reg(CFG_REPEAT_TICK, rt);
        cfg_valid = 1'b0;
        settings_used++;
        case (idle_kind)
            IDLE_SENDER: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            IDLE_RECV:   begin send_idle_pct = 0;  recv_stall_pct = 52; end
            IDLE_BOTH:   begin send_idle_pct = 37; recv_stall_pct = 37; end
            default:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        send_random(n);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = CFG_TOP_VALUE;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (PRESS_TABLE[i])
            send_buttons(PRESS_TABLE[i].buttons, PRESS_TABLE[i].pinned, PRESS_TABLE[i].value);
        send_random(120);

        run_setting(8'd255, 8'd1, 8'd1, 8'd1, IDLE_SENDER, 150);
        run_setting(8'd1, 8'd255, 8'd255, 8'd255, IDLE_RECV, 120);
        run_setting(8'($urandom_range(255, 1)), 8'($urandom_range(8, 1)),
                    8'($urandom_range(8, 1)), 8'($urandom_range(8, 1)), IDLE_BOTH, 150);
        run_setting(8'd3, 8'd2, 8'd3, 8'd2, IDLE_NONE, 120);
        run_setting(8'($urandom_range(20, 1)), 8'($urandom_range(6, 1)),
                    8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)), IDLE_SENDER, 150);
        run_setting(8'd9, 8'd5, 8'd10, 8'd5, IDLE_BOTH, 150);

        drain_results();
        $display("Checked %0d values against %0d button words under %0d register settings,",
                 values_checked, words_in, settings_used);
        $display("with sender gaps, receiver stalls, both, and stretches of neither.");
        if (mismatches == 0 && expected_values.size() == 0) begin
            $display("** button_auto_repeat_up_down_counter: PASSED **");
        end else begin
            $display("%0d mismatches, %0d values missing", mismatches, expected_values.size());
            $display("** button_auto_repeat_up_down_counter: FAILED **");
        end
        $finish;
    end

endmodule
